>>> rtl/cnnr_pkg.sv
// shared types and constants for the capacitated nearest-neighbor route unit
`default_nettype none

package cnnr_pkg;

    localparam int COORD_W        = 16;
    localparam int DEM_W          = 17;
    localparam int CMD_W          = 2;
    localparam int STOP_W         = 6;
    localparam int DIMS_W         = 3;
    localparam int NLANE          = 4;
    localparam int SQ_W           = 2 * COORD_W;
    localparam int DIST_W         = SQ_W + 2;
    localparam int MAX_POINTS_DEF = 32;
    localparam int MAX_DIMS_DEF   = 4;

    localparam logic [DEM_W-1:0]  FULL_LOAD  = 17'h10000;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_SET_DEPOT = 2'd1,
        CMD_ADD       = 2'd2,
        CMD_SOLVE     = 2'd3
    } cnnr_code_t;

    typedef enum logic [1:0] {
        OUT_HEAD = 2'd0,
        OUT_CUST = 2'd1,
        OUT_TAIL = 2'd2
    } cnnr_out_kind_t;

    typedef struct packed {
        logic           clear;
        logic           set_depot;
        logic           add_cust;
        logic           solve_init;
        logic           scan_start;
        logic           take_best;
        logic           load_out;
        cnnr_out_kind_t out_kind;
    } cnnr_ctrl_t;

    typedef struct packed {
        logic scan_done;
        logic found;
    } cnnr_status_t;

endpackage

`default_nettype wire

>>> rtl/cnnr_in_if.sv
// input channel: command word with coordinates and demand
`default_nettype none

interface cnnr_in_if import cnnr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] coord_0;
    logic [COORD_W-1:0] coord_1;
    logic [COORD_W-1:0] coord_2;
    logic [COORD_W-1:0] coord_3;
    logic [DEM_W-1:0]   demand;

    modport source (
        output valid, command, coord_0, coord_1, coord_2, coord_3, demand,
        input  ready
    );

    modport sink (
        input  valid, command, coord_0, coord_1, coord_2, coord_3, demand,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/cnnr_out_if.sv
// output channel: one route stop per word
`default_nettype none

interface cnnr_out_if import cnnr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STOP_W-1:0] stop_index;
    logic              last_stop;
    logic              overflow;

    modport source (
        output valid, stop_index, last_stop, overflow,
        input  ready
    );

    modport sink (
        input  valid, stop_index, last_stop, overflow,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/cnnr_datapath.sv
// customer store, distance pipeline, best tracker and output word register
`default_nettype none

module cnnr_datapath import cnnr_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DIMS   = MAX_DIMS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cnnr_ctrl_t         ctrl,
    output cnnr_status_t            status,
    input  wire logic               cfg_we,
    input  wire logic [DIMS_W-1:0]  cfg_wdata,
    input  wire logic [COORD_W-1:0] coord_0,
    input  wire logic [COORD_W-1:0] coord_1,
    input  wire logic [COORD_W-1:0] coord_2,
    input  wire logic [COORD_W-1:0] coord_3,
    input  wire logic [DEM_W-1:0]   demand,
    output logic [STOP_W-1:0]       stop_index,
    output logic                    last_stop,
    output logic                    overflow
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef logic [MAX_DIMS-1:0][COORD_W-1:0] pos_t;

    // customer store, contents undefined until written
    pos_t             coord_mem [MAX_POINTS];
    logic [DEM_W-1:0] dem_mem   [MAX_POINTS];

    logic [NLANE-1:0][COORD_W-1:0] in_coords;
    logic [DIMS_W-1:0]             dims_eff;

    logic [DIMS_W-1:0]     dims_reg;
    pos_t                  depot_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  overflow_reg;
    logic [MAX_POINTS-1:0] visited_reg;
    logic [DEM_W-1:0]      remain_reg;
    pos_t                  cur_reg;

    logic             issuing_reg;
    logic [IDX_W-1:0] issue_idx_reg;

    // read stage
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    pos_t             rd_coords_reg;
    logic [DEM_W-1:0] rd_dem_reg;

    // difference stage
    logic [NLANE-1:0][COORD_W-1:0] diff_c;
    logic                          rd_elig;
    logic                          p2_valid_reg;
    logic                          p2_elig_reg;
    logic [IDX_W-1:0]              p2_idx_reg;
    pos_t                          p2_coords_reg;
    logic [DEM_W-1:0]              p2_dem_reg;
    logic [NLANE-1:0][COORD_W-1:0] p2_diff_reg;

    // square stage
    logic                       p3_valid_reg;
    logic                       p3_elig_reg;
    logic [IDX_W-1:0]           p3_idx_reg;
    pos_t                       p3_coords_reg;
    logic [DEM_W-1:0]           p3_dem_reg;
    logic [NLANE-1:0][SQ_W-1:0] p3_sq_reg;

    // pair sum stage
    logic                   p4_valid_reg;
    logic                   p4_elig_reg;
    logic [IDX_W-1:0]       p4_idx_reg;
    pos_t                   p4_coords_reg;
    logic [DEM_W-1:0]       p4_dem_reg;
    logic [1:0][SQ_W:0]     p4_psum_reg;

    logic [DIST_W-1:0] total_c;
    logic              better_c;

    logic              found_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    pos_t              best_coords_reg;
    logic [DEM_W-1:0]  best_dem_reg;

    logic [STOP_W-1:0] stop_reg;
    logic              last_reg;
    logic              ovf_reg;

    assign in_coords = {coord_3, coord_2, coord_1, coord_0};
    assign dims_eff  = (dims_reg > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg      <= DIMS_RESET;
            depot_reg     <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            visited_reg   <= '0;
            issuing_reg   <= 1'b0;
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dims_reg <= cfg_wdata;
            end
            if (ctrl.set_depot)
            begin
                depot_reg <= in_coords[MAX_DIMS-1:0];
            end
            if (ctrl.clear)
            begin
                count_reg <= '0;
            end
            else if (ctrl.add_cust)
            begin
                if (count_reg < CNT_W'(MAX_POINTS))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (ctrl.solve_init)
            begin
                visited_reg <= '0;
            end
            else if (ctrl.take_best)
            begin
                visited_reg[best_idx_reg] <= 1'b1;
            end

            // address sweep over the stored customers
            if (ctrl.scan_start)
            begin
                issuing_reg   <= (count_reg != '0);
                issue_idx_reg <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (issuing_reg)
                begin
                    if (CNT_W'(issue_idx_reg) + CNT_W'(1) == count_reg)
                    begin
                        issuing_reg <= 1'b0;
                    end
                    issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                end
                if (better_c)
                begin
                    found_reg <= 1'b1;
                end
            end
            rd_valid_reg <= issuing_reg && !ctrl.scan_start;
            p2_valid_reg <= rd_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    // customer store write port and registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.add_cust && (count_reg < CNT_W'(MAX_POINTS)))
        begin
            coord_mem[count_reg[IDX_W-1:0]] <= in_coords[MAX_DIMS-1:0];
            dem_mem[count_reg[IDX_W-1:0]]   <= demand;
        end
        if (issuing_reg)
        begin
            rd_coords_reg <= coord_mem[issue_idx_reg];
            rd_dem_reg    <= dem_mem[issue_idx_reg];
        end
        rd_idx_reg <= issue_idx_reg;
    end

    for (genvar k = 0; k < NLANE; k++)
    begin : g_lane
        if (k < MAX_DIMS)
        begin : g_used
            assign diff_c[k] = (dims_eff > DIMS_W'(k)) ?
                ((cur_reg[k] > rd_coords_reg[k]) ? cur_reg[k] - rd_coords_reg[k]
                                                 : rd_coords_reg[k] - cur_reg[k]) :
                '0;
        end
        else
        begin : g_unused
            assign diff_c[k] = '0;
        end
    end

    assign rd_elig  = !visited_reg[rd_idx_reg] && (rd_dem_reg <= remain_reg);
    assign total_c  = {1'b0, p4_psum_reg[0]} + {1'b0, p4_psum_reg[1]};
    // strict compare keeps the lowest index on ties
    assign better_c = p4_valid_reg && p4_elig_reg && (!found_reg || (total_c < best_d_reg));

    // distance pipeline and route payload
    always_ff @(posedge clk)
    begin
        p2_elig_reg   <= rd_elig;
        p2_idx_reg    <= rd_idx_reg;
        p2_coords_reg <= rd_coords_reg;
        p2_dem_reg    <= rd_dem_reg;
        p2_diff_reg   <= diff_c;

        p3_elig_reg   <= p2_elig_reg;
        p3_idx_reg    <= p2_idx_reg;
        p3_coords_reg <= p2_coords_reg;
        p3_dem_reg    <= p2_dem_reg;
        for (int k = 0; k < NLANE; k++)
        begin
            p3_sq_reg[k] <= SQ_W'(p2_diff_reg[k]) * SQ_W'(p2_diff_reg[k]);
        end

        p4_elig_reg    <= p3_elig_reg;
        p4_idx_reg     <= p3_idx_reg;
        p4_coords_reg  <= p3_coords_reg;
        p4_dem_reg     <= p3_dem_reg;
        p4_psum_reg[0] <= {1'b0, p3_sq_reg[0]} + {1'b0, p3_sq_reg[1]};
        p4_psum_reg[1] <= {1'b0, p3_sq_reg[2]} + {1'b0, p3_sq_reg[3]};

        if (better_c && !ctrl.scan_start)
        begin
            best_d_reg      <= total_c;
            best_idx_reg    <= p4_idx_reg;
            best_coords_reg <= p4_coords_reg;
            best_dem_reg    <= p4_dem_reg;
        end

        if (ctrl.solve_init)
        begin
            remain_reg <= FULL_LOAD;
            cur_reg    <= depot_reg;
        end
        else if (ctrl.take_best)
        begin
            remain_reg <= remain_reg - best_dem_reg;
            cur_reg    <= best_coords_reg;
        end

        if (ctrl.load_out)
        begin
            ovf_reg <= overflow_reg;
            case (ctrl.out_kind)
                OUT_HEAD:
                begin
                    stop_reg <= '0;
                    last_reg <= 1'b0;
                end
                OUT_CUST:
                begin
                    stop_reg <= STOP_W'(best_idx_reg) + STOP_W'(1);
                    last_reg <= 1'b0;
                end
                OUT_TAIL:
                begin
                    stop_reg <= '0;
                    last_reg <= 1'b1;
                end
                default:
                begin
                    stop_reg <= '0;
                    last_reg <= 1'b0;
                end
            endcase
        end
    end

    assign status.scan_done = !issuing_reg && !rd_valid_reg && !p2_valid_reg &&
                              !p3_valid_reg && !p4_valid_reg;
    assign status.found     = found_reg;

    assign stop_index = stop_reg;
    assign last_stop  = last_reg;
    assign overflow   = ovf_reg;

endmodule

`default_nettype wire

>>> rtl/cnnr_ctrl.sv
// route controller: command decode, scan sequencing and output word valid
`default_nettype none

module cnnr_ctrl import cnnr_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CMD_W-1:0] command,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cnnr_ctrl_t            ctrl,
    input  wire cnnr_status_t     status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_WAIT,
        S_STEP,
        S_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        ctrl.out_kind  = OUT_HEAD;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cnnr_code_t'(command))
                        CMD_CLEAR:     ctrl.clear     = 1'b1;
                        CMD_SET_DEPOT: ctrl.set_depot = 1'b1;
                        CMD_ADD:       ctrl.add_cust  = 1'b1;
                        CMD_SOLVE:
                        begin
                            ctrl.solve_init = 1'b1;
                            state_next      = S_HEAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_HEAD:
            begin
                if (slot_free)
                begin
                    ctrl.load_out  = 1'b1;
                    ctrl.out_kind  = OUT_HEAD;
                    out_valid_next = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan_start = 1'b1;
                state_next      = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.scan_done)
                begin
                    state_next = status.found ? S_STEP : S_TAIL;
                end
            end
            S_STEP:
            begin
                if (slot_free)
                begin
                    ctrl.load_out  = 1'b1;
                    ctrl.out_kind  = OUT_CUST;
                    ctrl.take_best = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_TAIL:
            begin
                if (slot_free)
                begin
                    ctrl.load_out  = 1'b1;
                    ctrl.out_kind  = OUT_TAIL;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/capacitated_nearest_neighbor_route_unit.sv
// commands: clear, set depot and add customer are decoded and applied in the idle state
// solve: per route stop one sweep over the N stored customers (one store read per cycle)
// full route of R customers: R + 1 sweeps, the last one finding no candidate
// input: one word at a time, next word taken once the closing stop is loaded
// reset: async active low, clears control, depot, count, flags; store undefined until written
`default_nettype none

module capacitated_nearest_neighbor_route_unit import cnnr_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DIMS   = MAX_DIMS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cnnr_in_if.sink                in_ch,
    cnnr_out_if.source             out_ch,
    input  wire logic              cfg_we,
    input  wire logic [DIMS_W-1:0] cfg_wdata
);

    cnnr_ctrl_t   ctrl;
    cnnr_status_t status;

    cnnr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .command   (in_ch.command),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctrl      (ctrl),
        .status    (status)
    );

    cnnr_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .coord_0    (in_ch.coord_0),
        .coord_1    (in_ch.coord_1),
        .coord_2    (in_ch.coord_2),
        .coord_3    (in_ch.coord_3),
        .demand     (in_ch.demand),
        .stop_index (out_ch.stop_index),
        .last_stop  (out_ch.last_stop),
        .overflow   (out_ch.overflow)
    );

`ifndef SYNTH
    // a new word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> (!out_ch.valid || out_ch.ready))
        else $error("output word overwritten");

    a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.take_best |-> status.found)
        else $error("customer taken without a candidate");

    a_no_input_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !status.scan_done |-> !in_ch.ready)
        else $error("input taken during scan");

    a_rescan_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.take_best |=> ctrl.scan_start)
        else $error("no scan after customer taken");
`endif

endmodule

`default_nettype wire

>>> test/capacitated_nearest_neighbor_route_unit_tb.sv
`timescale 1ns / 100ps
// testbench for the route unit: directed and random load and solve words checked against a route predictor

module capacitated_nearest_neighbor_route_unit_tb;
    import cnnr_pkg::*;

    localparam int STORE_DEPTH = MAX_POINTS_DEF;
    localparam int GAP_MAX     = 17;
    localparam int PHASE_WORDS = 34;
    localparam int SETTLE      = 16;

    localparam logic [DIMS_W-1:0] DIMS_PLAN [8] =
        '{3'd0, 3'd1, 3'd4, 3'd7, 3'd3, 3'd5, 3'd6, 3'd2};

    typedef logic [NLANE-1:0][COORD_W-1:0] point_t;

    typedef struct packed {
        cnnr_code_t       cmd;
        point_t           pos;
        logic [DEM_W-1:0] dem;
    } job_word_t;

    typedef struct packed {
        logic [STOP_W-1:0] stop;
        logic              last;
        logic              ovf;
    } stop_word_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [DIMS_W-1:0] cfg_wdata;

    cnnr_in_if  in_ch();
    cnnr_out_if out_ch();

    capacitated_nearest_neighbor_route_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    point_t            depot_pos;
    point_t            cust_pos [STORE_DEPTH];
    logic [DEM_W-1:0]  cust_dem [STORE_DEPTH];
    int                cust_cnt;
    logic              ovf_flag;
    logic [DIMS_W-1:0] dims_reg;

    job_word_t  pend_q [$];
    stop_word_t stop_q [$];
    job_word_t  drv_word;
    int         words_sent;
    int         mismatch_cnt;
    bit         in_took;
    bit         out_took;
    int         in_gap;
    int         out_stall;
    bit         in_calm;
    bit         out_calm;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [DIST_W-1:0] span2(point_t a, point_t b, int nd);
        logic [DIST_W-1:0] acc;
        logic [DIST_W-1:0] diff;
        acc = '0;
        for (int k = 0; k < nd; k++)
        begin
            diff = (a[k] > b[k]) ? a[k] - b[k] : b[k] - a[k];
            acc += diff * diff;
        end
        return acc;
    endfunction

    function automatic point_t flat(logic [COORD_W-1:0] v);
        return {NLANE{v}};
    endfunction

    // mostly full-range points, some drawn from a few values so distances tie
    function automatic point_t rand_pos();
        point_t p;
        logic [COORD_W-1:0] picks [4];
        bit coarse;
        picks = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        coarse = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < NLANE; k++)
            p[k] = coarse ? picks[$urandom_range(0, 3)] : COORD_W'($urandom);
        return p;
    endfunction

    function automatic logic [DEM_W-1:0] rand_dem();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FULL_LOAD;
            2: return DEM_W'($urandom_range(17'h1FFFF, 17'h10001));
            3, 4, 5, 6: return DEM_W'($urandom_range(0, 16383));
            default: return DEM_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic predict_stops(job_word_t w);
        int                nd;
        logic [DEM_W-1:0]  remain;
        bit [STORE_DEPTH-1:0] seen;
        point_t            here;
        bit                found;
        int                best;
        logic [DIST_W-1:0] best_d;
        logic [DIST_W-1:0] d;
        case (w.cmd)
            CMD_CLEAR: cust_cnt = 0;
            CMD_SET_DEPOT: depot_pos = w.pos;
            CMD_ADD:
            begin
                if (cust_cnt < STORE_DEPTH)
                begin
                    cust_pos[cust_cnt] = w.pos;
                    cust_dem[cust_cnt] = w.dem;
                    cust_cnt++;
                end
                else
                    ovf_flag = 1'b1;
            end
            default:
            begin
                nd = (dims_reg > MAX_DIMS_DEF) ? MAX_DIMS_DEF : int'(dims_reg);
                remain = FULL_LOAD;
                seen = '0;
                here = depot_pos;
                stop_q.insert(stop_q.size(), '{stop: '0, last: 1'b0, ovf: ovf_flag});
                found = 1'b1;
                while (found)
                begin
                    found = 1'b0;
                    best = 0;
                    best_d = '0;
                    for (int i = 0; i < cust_cnt; i++)
                    begin
                        if (!seen[i] && cust_dem[i] <= remain)
                        begin
                            d = span2(here, cust_pos[i], nd);
                            // strict compare keeps the lowest index on a tie
                            if (!found || d < best_d)
                            begin
                                found = 1'b1;
                                best_d = d;
                                best = i;
                            end
                        end
                    end
                    if (found)
                    begin
                        seen[best] = 1'b1;
                        remain -= cust_dem[best];
                        here = cust_pos[best];
                        stop_q.insert(stop_q.size(),
                                      '{stop: STOP_W'(best + 1), last: 1'b0, ovf: ovf_flag});
                    end
                end
                stop_q.insert(stop_q.size(), '{stop: '0, last: 1'b1, ovf: ovf_flag});
            end
        endcase
    endtask

    // input driver
    always @(negedge clk)
    begin : drive_in
        job_word_t w;
        if (rst_n && (!in_ch.valid || in_took))
        begin
            if (in_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                in_gap--;
            end
            else if (pend_q.size() > 0)
            begin
                w = pend_q.pop_front();
                drv_word = w;
                in_ch.command <= w.cmd;
                in_ch.coord_0 <= w.pos[0];
                in_ch.coord_1 <= w.pos[1];
                in_ch.coord_2 <= w.pos[2];
                in_ch.coord_3 <= w.pos[3];
                in_ch.demand  <= w.dem;
                in_ch.valid   <= 1'b1;
                in_gap = draw_wait(in_calm);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_took = rst_n && in_ch.valid && in_ch.ready;
        if (in_took)
            predict_stops(drv_word);
    end

    // output stall pattern, one draw per word taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
                out_stall = draw_wait(out_calm);
            if (out_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                out_stall--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // route monitor
    always @(posedge clk)
    begin : watch_out
        stop_word_t e;
        out_took = rst_n && out_ch.valid && out_ch.ready;
        if (out_took)
        begin
            if (stop_q.size() == 0)
            begin
                $error("stop_index: no stop expected, got %0d", out_ch.stop_index);
                mismatch_cnt++;
            end
            else
            begin
                e = stop_q.pop_front();
                if (out_ch.stop_index !== e.stop)
                begin
                    $error("stop_index: expected %0d, got %0d", e.stop, out_ch.stop_index);
                    mismatch_cnt++;
                end
                if (out_ch.last_stop !== e.last)
                begin
                    $error("last_stop: expected %0d, got %0d", e.last, out_ch.last_stop);
                    mismatch_cnt++;
                end
                if (out_ch.overflow !== e.ovf)
                begin
                    $error("overflow: expected %0d, got %0d", e.ovf, out_ch.overflow);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic push_word(cnnr_code_t c, point_t p, logic [DEM_W-1:0] dm);
        pend_q.insert(pend_q.size(), '{cmd: c, pos: p, dem: dm});
        words_sent++;
    endtask

    // clear, depot, n customers, solve; clear and depot are sometimes left out
    task automatic route_batch(int n);
        if ($urandom_range(0, 4) != 0)
            push_word(CMD_CLEAR, rand_pos(), DEM_W'($urandom));
        if ($urandom_range(0, 3) != 0)
            push_word(CMD_SET_DEPOT, rand_pos(), DEM_W'($urandom));
        repeat (n)
            push_word(CMD_ADD, rand_pos(), rand_dem());
        push_word(CMD_SOLVE, rand_pos(), DEM_W'($urandom));
    endtask

    task automatic fill_phase(int budget);
        int stop_at;
        stop_at = words_sent + budget;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
                route_batch(($urandom_range(0, 9) == 0) ? $urandom_range(20, 36)
                                                          : $urandom_range(0, 10));
            else
                push_word(cnnr_code_t'($urandom_range(int'(CMD_SOLVE), int'(CMD_CLEAR))),
                          rand_pos(), DEM_W'($urandom_range(0, 17'h1FFFF)));
        end
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || in_ch.valid || stop_q.size() != 0)
            @(posedge clk);
        // loads leave no word behind, give the last one time to settle
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_dims(logic [DIMS_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        dims_reg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_CLEAR;
        in_ch.coord_0 = '0;
        in_ch.coord_1 = '0;
        in_ch.coord_2 = '0;
        in_ch.coord_3 = '0;
        in_ch.demand  = '0;
        out_ch.ready  = 1'b0;
        depot_pos     = '0;
        cust_cnt      = 0;
        ovf_flag      = 1'b0;
        dims_reg      = DIMS_RESET;
        words_sent    = 0;
        mismatch_cnt  = 0;
        in_took       = 1'b0;
        out_took      = 1'b0;
        in_gap        = 0;
        out_stall     = 0;
        in_calm       = 1'b0;
        out_calm      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty route, ties, full load, oversized demand, unused lanes
        push_word(CMD_SOLVE, flat(16'h0000), '0);
        push_word(CMD_SET_DEPOT, flat(16'hFFFF), 17'h1FFFF);
        push_word(CMD_ADD, flat(16'h0000), '0);
        push_word(CMD_ADD, flat(16'hFFFF), FULL_LOAD);
        push_word(CMD_ADD, flat(16'h8000), 17'h1FFFF);
        push_word(CMD_ADD, flat(16'hFFFF), '0);
        push_word(CMD_ADD, {16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF}, 17'h08000);
        push_word(CMD_ADD, {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, '0);
        push_word(CMD_SOLVE, flat(16'hFFFF), FULL_LOAD);
        push_word(CMD_CLEAR, flat(16'hFFFF), 17'h1FFFF);
        push_word(CMD_SOLVE, flat(16'h0000), '0);
        push_word(CMD_SET_DEPOT, {16'hAAAA, 16'h5555, 16'h0001, 16'h8000}, '0);
        push_word(CMD_ADD, rand_pos(), FULL_LOAD);
        push_word(CMD_ADD, rand_pos(), 17'h00001);
        push_word(CMD_ADD, rand_pos(), 17'h10001);
        push_word(CMD_SOLVE, rand_pos(), '0);
        drain();

        for (int p = 0; p < $size(DIMS_PLAN); p++)
        begin
            write_dims(DIMS_PLAN[p]);
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            // first phase overruns the store once so the flag goes up
            if (p == 0)
                route_batch(STORE_DEPTH + 2);
            fill_phase(PHASE_WORDS);
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        if (mismatch_cnt == 0 && stop_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
